FILE: rtl/aes_block_encrypt_unit_macros.svh
// assertion macros for the aes block encrypt unit
// used by aes_block_encrypt_unit, expects aclk and aresetn in scope
`ifndef AES_BLOCK_ENCRYPT_UNIT_MACROS_SVH
`define AES_BLOCK_ENCRYPT_UNIT_MACROS_SVH
`define AES_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`define AES_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: rtl/aes_pkg.sv
// aes constants, s-box and round functions
// no dependencies
package aes_pkg;

    localparam int NR_MAX   = 14;
    localparam int WORD_MAX = 60;

    localparam logic [2:0] REG_KEY_LENGTH = 3'd0;
    localparam logic [2:0] REG_KEY_3      = 3'd1;
    localparam logic [2:0] REG_KEY_2      = 3'd2;
    localparam logic [2:0] REG_KEY_1      = 3'd3;
    localparam logic [2:0] REG_KEY_0      = 3'd4;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] x);
        xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // byte n of the block sits at bits [127-8n -: 8]
    function automatic logic [127:0] sub_shift(input logic [127:0] s);
        logic [127:0] t;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8 * (r + 4 * c) -: 8] = SBOX[s[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8]];
            end
        end
        sub_shift = t;
    endfunction

    function automatic logic [127:0] mix_cols(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0]   a0, a1, a2, a3, al;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            a0 = s[127 - 32 * c -: 8];
            a1 = s[119 - 32 * c -: 8];
            a2 = s[111 - 32 * c -: 8];
            a3 = s[103 - 32 * c -: 8];
            al = a0 ^ a1 ^ a2 ^ a3;
            t[127 - 32 * c -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
            t[119 - 32 * c -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
            t[111 - 32 * c -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
            t[103 - 32 * c -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
        end
        mix_cols = t;
    endfunction

endpackage

FILE: rtl/aes_block_encrypt_unit.sv
// throughput: one block per cycle while m_tready is high and no key expansion runs;
// 15 round stages each hold one block
// round keys expand one word per cycle after reset and after each register write:
// 44, 52 or 60 words for 128, 192 or 256 bit keys, with s_tready low meanwhile
// aresetn is synchronous, active low; resets key and valid regs, starts expansion
`include "aes_block_encrypt_unit_macros.svh"
module aes_block_encrypt_unit import aes_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [5:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // plain_high [63:0], plain_low [127:64]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata    // cipher_high [63:0], cipher_low [127:64]
);

    logic [1:0]   key_length_reg;
    logic [63:0]  key_reg [4];
    logic         busy_reg;
    logic [5:0]   idx_reg;
    logic [2:0]   mod_reg;
    logic [7:0]   rcon_reg;
    logic [31:0]  win_reg [8];
    logic [127:0] rk_reg [NR_MAX + 1];
    logic [127:0] st_reg [NR_MAX + 1];
    logic         v_reg [NR_MAX + 1];
    logic         rdy [NR_MAX + 1];

    logic         cfg_wr;
    logic [2:0]   cfg_idx;
    logic [1:0]   sel;
    logic [3:0]   nk;
    logic [3:0]   nr;
    logic [5:0]   last_idx;
    logic [31:0]  key_words [8];
    logic [31:0]  prev_w, far_w, tmp_w, new_w;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[5:3];

    always_comb begin
        case (cfg_idx)
            REG_KEY_LENGTH: prdata = {62'd0, key_length_reg};
            REG_KEY_3:      prdata = key_reg[0];
            REG_KEY_2:      prdata = key_reg[1];
            REG_KEY_1:      prdata = key_reg[2];
            REG_KEY_0:      prdata = key_reg[3];
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_length_reg <= '0;
            for (int i = 0; i < 4; i++) key_reg[i] <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_KEY_LENGTH: key_length_reg <= pwdata[1:0];
                REG_KEY_3:      key_reg[0] <= pwdata;
                REG_KEY_2:      key_reg[1] <= pwdata;
                REG_KEY_1:      key_reg[2] <= pwdata;
                REG_KEY_0:      key_reg[3] <= pwdata;
                default:        ;
            endcase
        end
    end

    // key expansion, one word per cycle
    assign sel      = (key_length_reg == 2'd3) ? 2'd2 : key_length_reg;
    assign nk       = 4'd4 + {1'b0, sel, 1'b0};
    assign nr       = nk + 4'd6;
    assign last_idx = {nk, 2'b00} + 6'd27;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            key_words[2 * i]     = key_reg[i][63:32];
            key_words[2 * i + 1] = key_reg[i][31:0];
        end
        prev_w = win_reg[7];
        case (sel)
            2'd0:    far_w = win_reg[4];
            2'd1:    far_w = win_reg[2];
            default: far_w = win_reg[0];
        endcase
        if (mod_reg == 3'd0) begin
            tmp_w = sub_word({prev_w[23:0], prev_w[31:24]}) ^ {rcon_reg, 24'd0};
        end else if (nk == 4'd8 && mod_reg == 3'd4) begin
            tmp_w = sub_word(prev_w);
        end else begin
            tmp_w = prev_w;
        end
        if (idx_reg < {2'b00, nk}) begin
            new_w = key_words[idx_reg[2:0]];
        end else begin
            new_w = far_w ^ tmp_w;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_wr) begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
            mod_reg  <= '0;
            rcon_reg <= 8'h01;
        end else if (busy_reg) begin
            idx_reg <= idx_reg + 6'd1;
            if (idx_reg == last_idx) busy_reg <= 1'b0;
            if ({1'b0, mod_reg} == nk - 4'd1) begin
                mod_reg <= '0;
            end else begin
                mod_reg <= mod_reg + 3'd1;
            end
            if (idx_reg >= {2'b00, nk} && mod_reg == 3'd0) rcon_reg <= xtime(rcon_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            for (int i = 0; i < 7; i++) win_reg[i] <= win_reg[i + 1];
            win_reg[7] <= new_w;
            rk_reg[idx_reg[5:2]][127 - 32 * idx_reg[1:0] -: 32] <= new_w;
        end
    end

    // round pipeline, each stage moves when it is empty or the next one moves
    always_comb begin
        rdy[NR_MAX] = !v_reg[NR_MAX] || m_tready;
        for (int k = NR_MAX - 1; k >= 0; k--) rdy[k] = !v_reg[k] || rdy[k + 1];
    end

    assign s_tready = rdy[0] && !busy_reg;
    assign m_tvalid = v_reg[NR_MAX];
    assign m_tdata  = {st_reg[NR_MAX][63:0], st_reg[NR_MAX][127:64]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (rdy[0]) begin
            v_reg[0] <= s_tvalid && s_tready;
        end
        if (rdy[0]) st_reg[0] <= {s_tdata[63:0], s_tdata[127:64]} ^ rk_reg[0];
    end

    for (genvar k = 1; k <= NR_MAX; k++) begin : g_round
        logic [127:0] sh, mx, nx;
        always_comb begin
            sh = sub_shift(st_reg[k - 1]);
            mx = (nr == 4'(k)) ? sh : mix_cols(sh);
            nx = (4'(k) > nr) ? st_reg[k - 1] : (mx ^ rk_reg[k]);
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (rdy[k]) begin
                v_reg[k] <= v_reg[k - 1];
            end
            if (rdy[k]) st_reg[k] <= nx;
        end
    end

    `AES_ASSERT_IMP(a_busy_blocks_input, busy_reg, !s_tready, "input taken during key expansion")
    `AES_ASSERT_NXT(a_cfg_starts_expand, cfg_wr, busy_reg && idx_reg == 6'd0, "expansion not restarted")
    `AES_ASSERT_IMP(a_idx_in_range, busy_reg, idx_reg < 6'(WORD_MAX), "key word index out of range")
    `AES_ASSERT_NXT(a_out_held, m_tvalid && !m_tready, m_tvalid, "result dropped under stall")

endmodule

FILE: dv/aes_encrypt_checker.sv
`timescale 1ns / 100ps
// checker for the aes block encrypt unit: tracks key registers from the apb bus,
// predicts the ciphertext of each input transfer and compares it on the output side
// depends on aes_pkg for the s-box and register indexes
module aes_encrypt_checker import aes_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [5:0]   paddr,
    input  logic [63:0]  pwdata,
    input  logic         pready,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [127:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [127:0] m_tdata,
    output int           fail_count,
    output int           pending
);

    logic [1:0]   key_len_q;
    logic [63:0]  key_q [4];
    logic [127:0] cipher_fifo [$];

    function automatic logic [7:0] gf_double(input logic [7:0] x);
        gf_double = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [127:0] encrypt_block(input logic [127:0] blk);
        logic [7:0]   kb [32];
        logic [7:0]   st [16];
        logic [7:0]   tmp [16];
        logic [31:0]  w [60];
        logic [31:0]  t;
        logic [7:0]   rc, a0, a1, a2, a3, al;
        logic [127:0] res;
        int           nk, nr, tot;
        nk = (key_len_q == 2'd0) ? 4 : (key_len_q == 2'd1) ? 6 : 8;
        nr = nk + 6;
        tot = 4 * (nr + 1);
        rc = 8'h01;
        for (int i = 0; i < 32; i++) kb[i] = key_q[i / 8][63 - 8 * (i % 8) -: 8];
        for (int i = 0; i < nk; i++)
            w[i] = {kb[4 * i], kb[4 * i + 1], kb[4 * i + 2], kb[4 * i + 3]};
        for (int i = nk; i < tot; i++) begin
            t = w[i - 1];
            if (i % nk == 0) begin
                t = {t[23:0], t[31:24]};
                t = {SBOX[t[31:24]], SBOX[t[23:16]], SBOX[t[15:8]], SBOX[t[7:0]]};
                t = t ^ {rc, 24'h0};
                rc = gf_double(rc);
            end else if (nk > 6 && i % nk == 4) begin
                t = {SBOX[t[31:24]], SBOX[t[23:16]], SBOX[t[15:8]], SBOX[t[7:0]]};
            end
            w[i] = w[i - nk] ^ t;
        end
        for (int n = 0; n < 16; n++) st[n] = blk[127 - 8 * n -: 8];
        for (int r = 0; r <= nr; r++) begin
            if (r > 0) begin
                for (int c = 0; c < 4; c++)
                    for (int b = 0; b < 4; b++)
                        tmp[b + 4 * c] = SBOX[st[b + 4 * ((c + b) % 4)]];
                st = tmp;
                if (r < nr) begin
                    for (int c = 0; c < 4; c++) begin
                        a0 = st[4 * c]; a1 = st[4 * c + 1];
                        a2 = st[4 * c + 2]; a3 = st[4 * c + 3];
                        al = a0 ^ a1 ^ a2 ^ a3;
                        st[4 * c]     = a0 ^ al ^ gf_double(a0 ^ a1);
                        st[4 * c + 1] = a1 ^ al ^ gf_double(a1 ^ a2);
                        st[4 * c + 2] = a2 ^ al ^ gf_double(a2 ^ a3);
                        st[4 * c + 3] = a3 ^ al ^ gf_double(a3 ^ a0);
                    end
                end
            end
            for (int c = 0; c < 4; c++)
                for (int b = 0; b < 4; b++)
                    st[4 * c + b] = st[4 * c + b] ^ w[r * 4 + c][31 - 8 * b -: 8];
        end
        for (int n = 0; n < 16; n++) res[127 - 8 * n -: 8] = st[n];
        encrypt_block = res;
    endfunction

    always @(posedge aclk) begin
        logic [127:0] exp_c;
        logic [2:0]   idx;
        int           errs;
        if (!aresetn) begin
            key_len_q <= '0;
            for (int i = 0; i < 4; i++) key_q[i] <= '0;
            cipher_fifo.delete();
            fail_count <= 0;
            pending <= 0;
        end else begin
            errs = 0;
            idx = paddr[5:3];
            if (psel && penable && pwrite && pready) begin
                if (idx == REG_KEY_LENGTH) begin
                    key_len_q <= (pwdata[1:0] == 2'd3) ? 2'd2 : pwdata[1:0];
                end else if (idx <= REG_KEY_0) begin
                    key_q[2'(idx - 3'd1)] <= pwdata;
                end
            end
            if (s_tvalid && s_tready)
                cipher_fifo = {cipher_fifo, encrypt_block({s_tdata[63:0], s_tdata[127:64]})};
            if (m_tvalid && m_tready) begin
                if (cipher_fifo.size() == 0) begin
                    $error("output transfer with no block outstanding");
                    errs++;
                end else begin
                    exp_c = cipher_fifo.pop_front();
                    if (m_tdata[63:0] !== exp_c[127:64]) begin
                        $error("cipher_high expected %h actual %h", exp_c[127:64], m_tdata[63:0]);
                        errs++;
                    end
                    if (m_tdata[127:64] !== exp_c[63:0]) begin
                        $error("cipher_low expected %h actual %h", exp_c[63:0], m_tdata[127:64]);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
            pending <= cipher_fifo.size();
        end
    end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// top of the aes block encrypt unit testbench: clock, reset, apb key setup and block stimulus
// depends on aes_pkg, aes_block_encrypt_unit and aes_encrypt_checker
module tb_top import aes_pkg::*;;

    localparam int CYCLE_LIMIT = 600000;

    logic         aclk;
    logic         aresetn;
    logic         psel, penable, pwrite;
    logic [5:0]   paddr;
    logic [63:0]  pwdata;
    logic [63:0]  prdata;
    logic         pready;
    logic         s_tvalid, s_tready;
    logic [127:0] s_tdata;   // plain_high [63:0], plain_low [127:64]
    logic         m_tvalid, m_tready;
    logic [127:0] m_tdata;   // cipher_high [63:0], cipher_low [127:64]
    int           fail_count, pending, cycle_cnt;
    logic         burst_mode;

    aes_block_encrypt_unit u_top (.*);

    aes_encrypt_checker u_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) pick_gap = 0;
        else if (r < 95) pick_gap = $urandom_range(1, 3);
        else pick_gap = $urandom_range(10, 40);
    endfunction

    // receiver side, with one long hold-off so the pipeline fills
    initial begin
        int run_len, gap;
        bit long_done;
        long_done = 0;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            run_len = $urandom_range(1, 30);
            m_tready <= 1'b1;
            repeat (run_len) @(posedge aclk);
            if (!long_done && cycle_cnt > 4000) begin
                long_done = 1;
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
            end else begin
                gap = pick_gap();
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end
    end

    task automatic apb_write(input logic [2:0] idx, input logic [63:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_block(input logic [63:0] hi, input logic [63:0] lo);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata <= {lo, hi};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        gap = burst_mode ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic load_key(input logic [1:0] len, input logic [63:0] k3, input logic [63:0] k2,
                            input logic [63:0] k1, input logic [63:0] k0);
        apb_write(REG_KEY_LENGTH, {62'h0, len});
        apb_write(REG_KEY_3, k3);
        apb_write(REG_KEY_2, k2);
        apb_write(REG_KEY_1, k1);
        apb_write(REG_KEY_0, k0);
    endtask

    initial begin
        logic [63:0] ones;
        ones = '1;
        burst_mode = 1'b0;
        aresetn <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset key, extreme blocks
        send_block(64'h0, 64'h0);
        send_block(ones, ones);
        send_block(64'ha5a5a5a5a5a5a5a5, 64'h5a5a5a5a5a5a5a5a);
        send_block(64'h8000000000000001, 64'h0000000180000000);
        drain();

        // standard vectors for each key size
        load_key(2'd0, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, ones, ones);
        send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
        send_block(ones, 64'h0);
        drain();
        load_key(2'd1, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h1011121314151617, ones);
        send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
        send_block(64'h0, ones);
        drain();
        load_key(2'd2, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h1011121314151617,
                 64'h18191a1b1c1d1e1f);
        send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
        drain();
        // unused key length code, then all-ones key
        load_key(2'd3, ones, ones, ones, ones);
        send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
        send_block(ones, ones);
        drain();
        // write to an address beyond the register map
        apb_write(3'd5, ones);
        apb_write(3'd7, 64'h0);
        send_block(64'h0, 64'h0);
        drain();

        for (int ph = 0; ph < 12; ph++) begin
            if (ph == 4) load_key(2'd0, 64'h0, 64'h0, ones, ones);
            else if (ph == 7) load_key(2'd2, ones, ones, ones, ones);
            else load_key(2'(ph % 4), {$urandom, $urandom}, {$urandom, $urandom},
                          {$urandom, $urandom}, {$urandom, $urandom});
            burst_mode = (ph % 3 == 0);
            for (int i = 0; i < 150; i++)
                send_block({$urandom, $urandom}, {$urandom, $urandom});
            drain();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
